[hw/rtl/transport_frame_checker_top_defines.svh]
// Assertion macros shared by the frame checker RTL
`ifndef TRANSPORT_FRAME_CHECKER_TOP_DEFINES_SVH
`define TRANSPORT_FRAME_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define TFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame checker: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame checker: next-cycle check failed");

`endif

[hw/rtl/tfc_pkg.sv]
// Shared constants, result type and CRC-32 byte update for the frame checker
package tfc_pkg;

    localparam int unsigned CountWidth = 32;
    localparam logic [31:0] ErrorWord  = 32'hffff_fe6c;
    localparam logic [CountWidth-1:0] MinFrame    = CountWidth'(12);
    localparam logic [CountWidth-1:0] ErrorFrame  = CountWidth'(16);
    localparam logic [CountWidth-1:0] HeaderBytes = CountWidth'(4);
    localparam logic [CountWidth-1:0] SeqEnd      = CountWidth'(8);
    localparam logic [31:0] CrcPoly = 32'hedb8_8320;
    localparam logic [31:0] CrcInit = 32'hffff_ffff;

    typedef struct packed {
        logic        has_result;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_end;
        logic        length_error;
        logic        crc_error;
        logic        remote_error;
        logic        short_frame;
        logic [31:0] sequence_number;
    } t_result;

    // Reflected CRC-32 update for one byte, bit at a time
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/tfc_tracker.sv]
// Frame state tracker: byte counter, trailer window, CRC and header capture
module tfc_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output tfc_pkg::t_result o_result
);
    import tfc_pkg::*;

    logic [CountWidth-1:0] r_count, n_count;
    logic [31:0] r_window, n_window;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_hdr, n_hdr;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_first, n_first;
    logic        is_short;

    always_comb begin
        n_crc    = (r_count >= HeaderBytes) ? crc_feed(r_crc, r_window[7:0]) : r_crc;
        n_window = {i_data_byte, r_window[31:8]};
        n_hdr    = r_hdr;
        n_seq    = r_seq;
        n_first  = r_first;
        if (r_count < HeaderBytes) begin
            n_hdr[{r_count[1:0], 3'b000} +: 8] = i_data_byte;
        end else if (r_count < SeqEnd) begin
            n_seq[{r_count[1:0], 3'b000} +: 8] = i_data_byte;
        end else if (r_count < MinFrame) begin
            n_first[{r_count[1:0], 3'b000} +: 8] = i_data_byte;
        end
        n_count  = (&r_count) ? r_count : r_count + CountWidth'(1);
        is_short = n_count < MinFrame;

        o_result                 = '0;
        o_result.has_result      = (r_count >= MinFrame) || i_last_byte;
        if (r_count >= MinFrame) begin
            o_result.payload_byte  = r_window[7:0];
            o_result.payload_valid = 1'b1;
        end
        if (i_last_byte) begin
            o_result.frame_end       = 1'b1;
            o_result.length_error    = n_hdr != n_count;
            o_result.crc_error       = (n_crc ^ CrcInit) != n_window;
            o_result.remote_error    = !is_short && (n_count == ErrorFrame)
                                       && (n_first == ErrorWord);
            o_result.short_frame     = is_short;
            o_result.sequence_number = n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_window <= '0;
            r_crc    <= CrcInit;
            r_hdr    <= '0;
            r_seq    <= '0;
            r_first  <= '0;
        end else if (i_advance) begin
            if (i_last_byte) begin
                // drop all frame state for the next frame
                r_count  <= '0;
                r_window <= '0;
                r_crc    <= CrcInit;
                r_hdr    <= '0;
                r_seq    <= '0;
                r_first  <= '0;
            end else begin
                r_count  <= n_count;
                r_window <= n_window;
                r_crc    <= n_crc;
                r_hdr    <= n_hdr;
                r_seq    <= n_seq;
                r_first  <= n_first;
            end
        end
    end

endmodule

[hw/rtl/transport_frame_checker_top.sv]
// Top level of the transport frame checker: input stage, tracker, result register
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | i_data_byte, i_last_byte
//  out     | from block| o_out_valid / i_out_ready | o_payload_byte ... o_sequence_number
//
// One byte per cycle while the output does not stall: a transfer lands in the input
// register; as the byte advances, the tracker's one-byte CRC update and header capture
// run and the result register loads. Bytes that produce no result (header bytes while
// the window fills) are consumed without touching the output.
// Reset (i_rst_n low, synchronous) empties both registers and clears the frame state.
// A stalled output holds the result register; the input register then holds too, and
// o_in_ready drops only when both are full.
`include "transport_frame_checker_top_defines.svh"

module transport_frame_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_frame_end,
    output logic        o_length_error,
    output logic        o_crc_error,
    output logic        o_remote_error,
    output logic        o_short_frame,
    output logic [31:0] o_sequence_number
);
    import tfc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    trk_result;
    logic       advance;

    // Advance the held byte whenever the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    tfc_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_result    (trk_result)
    );

    // Input register: control state under reset, payload free-running on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Result register: load on advance when the byte produces a result,
    // otherwise empty on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= trk_result.has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && trk_result.has_result) begin
            r_out <= trk_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_payload_valid   = r_out.payload_valid;
    assign o_frame_end       = r_out.frame_end;
    assign o_length_error    = r_out.length_error;
    assign o_crc_error       = r_out.crc_error;
    assign o_remote_error    = r_out.remote_error;
    assign o_short_frame     = r_out.short_frame;
    assign o_sequence_number = r_out.sequence_number;

    // A result that does not end a frame must carry a payload byte and no length or CRC error
    `TFC_ASSERT_IMPLY(a_mid_frame_payload, i_clk, i_rst_n, r_out_valid && !r_out.frame_end, r_out.payload_valid && !r_out.length_error && !r_out.crc_error)
    // A short frame never yields payload or a remote error
    `TFC_ASSERT_IMPLY(a_short_no_payload, i_clk, i_rst_n, r_out_valid && r_out.short_frame, !r_out.payload_valid && !r_out.remote_error)
    // Moving a last byte through always presents a frame-end result next cycle
    `TFC_ASSERT_NEXT(a_last_gives_end, i_clk, i_rst_n, advance && r_in_last, r_out_valid && r_out.frame_end)

endmodule

[dv/tb_top.sv]
// Self-checking testbench for transport_frame_checker_top: frame stimulus, byte-level predictor
`timescale 1ns / 100ps

module tb_top;

    // Frame layout and protocol constants
    localparam logic [31:0] MinFrameBytes = 32'd12;
    localparam logic [31:0] ErrorFrameLen = 32'd16;
    localparam logic [31:0] RemoteErrWord = 32'hffff_fe6c;
    localparam logic [31:0] CrcPolyRefl   = 32'hedb8_8320;
    localparam int          CycleLimit    = 200000;
    localparam int          ReportLimit   = 10;
    localparam int          PhaseBytes    = 388;

    typedef logic [7:0] byte_q_t[$];

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_LENGTH,
        FLAW_CRC
    } frame_flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last_flag;
    } link_byte_t;

    typedef struct packed {
        logic [7:0]  pl_byte;
        logic        pl_valid;
        logic        frame_end;
        logic        len_err;
        logic        crc_err;
        logic        remote_err;
        logic        short_frame;
        logic [31:0] seq_num;
    } frame_result_t;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Drive every block input to a known value from time zero
    logic        in_valid  = 1'b0;
    logic [7:0]  in_data   = 8'h00;
    logic        in_last   = 1'b0;
    logic        out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic        o_frame_end;
    logic        o_length_error;
    logic        o_crc_error;
    logic        o_remote_error;
    logic        o_short_frame;
    logic [31:0] o_sequence_number;

    // Stimulus and scoreboard storage
    link_byte_t    link_bytes[$];
    frame_result_t predicted_outputs[$];

    // Predictor copy of the frame tracker state
    logic [31:0] rx_count    = '0;
    logic [31:0] tail_window = '0;
    logic [31:0] crc_acc     = '1;
    logic [31:0] hdr_len     = '0;
    logic [31:0] seq_word    = '0;
    logic [31:0] first_word  = '0;

    // Bookkeeping
    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int results_checked = 0;
    int frames_closed   = 0;
    int len_err_frames  = 0;
    int crc_err_frames  = 0;
    int remote_frames   = 0;
    int short_frames    = 0;
    int fail_count      = 0;
    int cycle_count     = 0;
    int idle_pct        = 0;
    int stall_pct       = 0;
    bit byte_taken      = 1'b0;

    transport_frame_checker_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (in_data),
        .i_last_byte       (in_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_payload_byte    (o_payload_byte),
        .o_payload_valid   (o_payload_valid),
        .o_frame_end       (o_frame_end),
        .o_length_error    (o_length_error),
        .o_crc_error       (o_crc_error),
        .o_remote_error    (o_remote_error),
        .o_short_frame     (o_short_frame),
        .o_sequence_number (o_sequence_number)
    );

    // 20 ns period: high then low
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Reflected CRC-32, one data bit per iteration, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) c = c ^ CrcPolyRefl;
        end
        return c;
    endfunction

    function automatic string fmt_result(input frame_result_t r);
        return $sformatf("byte=%02h pv=%0b end=%0b len=%0b crc=%0b rem=%0b short=%0b seq=%08h",
                         r.pl_byte, r.pl_valid, r.frame_end, r.len_err, r.crc_err,
                         r.remote_err, r.short_frame, r.seq_num);
    endfunction

    // Count every failure; print only the first few
    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= ReportLimit) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Advance the predictor by one accepted byte and queue the result it causes
    task automatic track_frame_byte(input logic [7:0] d, input logic last_flag);
        logic [31:0]   pos;
        logic [7:0]    leaving;
        logic          emit;
        logic          is_short;
        frame_result_t r;
        pos     = rx_count;
        leaving = tail_window[7:0];
        emit    = (pos >= MinFrameBytes);
        // The byte leaving the delay window joins the CRC once the length field has passed
        if (pos >= 32'd4) crc_acc = crc32_byte(crc_acc, leaving);
        tail_window = {d, tail_window[31:8]};
        if (pos < 32'd4)
            hdr_len = hdr_len | (32'(d) << (8 * pos));
        else if (pos < 32'd8)
            seq_word = seq_word | (32'(d) << (8 * (pos - 32'd4)));
        else if (pos < 32'd12)
            first_word = first_word | (32'(d) << (8 * (pos - 32'd8)));
        if (rx_count != '1) rx_count = rx_count + 32'd1;
        if (emit || last_flag) begin
            r = '0;
            if (emit) begin
                r.pl_byte  = leaving;
                r.pl_valid = 1'b1;
            end
            if (last_flag) begin
                is_short     = (rx_count < MinFrameBytes);
                r.frame_end  = 1'b1;
                r.len_err    = (hdr_len != rx_count);
                r.crc_err    = ((crc_acc ^ 32'hffff_ffff) != tail_window);
                r.remote_err = !is_short && (rx_count == ErrorFrameLen) &&
                               (first_word == RemoteErrWord);
                r.short_frame = is_short;
                r.seq_num    = seq_word;
                frames_closed++;
                len_err_frames += r.len_err;
                crc_err_frames += r.crc_err;
                remote_frames  += r.remote_err;
                short_frames   += r.short_frame;
                // Frame closed: return to the post-reset state
                rx_count    = '0;
                tail_window = '0;
                crc_acc     = '1;
                hdr_len     = '0;
                seq_word    = '0;
                first_word  = '0;
            end
            predicted_outputs.push_back(r);
        end
    endtask

    // Append raw frame bytes to the link, marking the final one
    task automatic push_frame(input byte_q_t f);
        link_byte_t lb;
        foreach (f[i]) begin
            lb.data      = f[i];
            lb.last_flag = (i == f.size() - 1);
            link_bytes.push_back(lb);
        end
        bytes_queued += f.size();
    endtask

    // Build length, sequence, payload and CRC trailer; optionally corrupt one field
    task automatic queue_frame(input byte_q_t body, input logic [31:0] seq,
                               input frame_flaw_t flaw);
        byte_q_t     f;
        logic [31:0] len_field;
        logic [31:0] crc;
        logic [31:0] spoil;
        spoil = $urandom;
        if (spoil == 0) spoil = 32'h1;
        len_field = 32'(body.size()) + MinFrameBytes;
        if (flaw == FLAW_LENGTH) len_field = len_field ^ spoil;
        for (int i = 0; i < 4; i++) f.push_back(len_field[8*i +: 8]);
        for (int i = 0; i < 4; i++) f.push_back(seq[8*i +: 8]);
        foreach (body[i]) f.push_back(body[i]);
        crc = '1;
        foreach (f[i]) crc = crc32_byte(crc, f[i]);
        crc = ~crc;
        if (flaw == FLAW_CRC) crc = crc ^ spoil;
        for (int i = 0; i < 4; i++) f.push_back(crc[8*i +: 8]);
        push_frame(f);
    endtask

    // Mostly structured frames with random content, some flawed; the rest short or noise
    task automatic queue_random_frames(input int byte_budget);
        byte_q_t     body;
        int          start;
        int          pick;
        int          n;
        int          f;
        frame_flaw_t flaw;
        start = bytes_queued;
        while (bytes_queued - start < byte_budget) begin
            body.delete();
            pick = $urandom_range(99);
            if (pick < 84) begin
                if (pick < 12) begin
                    // Remote error payload, sometimes with one byte spoiled
                    body = '{8'h6c, 8'hfe, 8'hff, 8'hff};
                    if ($urandom_range(3) == 0) body[$urandom_range(3)] = 8'($urandom);
                end else begin
                    n = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(20);
                    repeat (n) body.push_back(8'($urandom));
                end
                f = $urandom_range(9);
                flaw = (f < 6) ? FLAW_NONE : (f < 8) ? FLAW_LENGTH : FLAW_CRC;
                queue_frame(body, $urandom, flaw);
            end else begin
                // Short frames below the minimum, or unstructured noise frames
                n = (pick < 93) ? $urandom_range(11, 1) : $urandom_range(30, 12);
                repeat (n) body.push_back(8'($urandom));
                push_frame(body);
            end
        end
    endtask

    // Cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("transport_frame_checker_top verification failed");
            $finish;
        end
    end

    // Input side: record each transfer and run it through the predictor
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && in_valid && o_in_ready;
        if (byte_taken) begin
            track_frame_byte(in_data, in_last);
            bytes_accepted++;
        end
    end

    // Driver: hold an offered byte until its transfer, then offer the next or idle
    always @(negedge i_clk) begin : drive_link
        link_byte_t nxt;
        if (in_valid && !byte_taken) begin
            // hold valid and payload steady until accepted
        end else if (link_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt = link_bytes.pop_front();
            in_valid <= 1'b1;
            in_data  <= nxt.data;
            in_last  <= nxt.last_flag;
        end else begin
            in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: compare every result transfer against the oldest prediction
    always @(posedge i_clk) begin : watch_results
        frame_result_t got;
        frame_result_t want;
        if (i_rst_n && o_out_valid && out_ready) begin
            got = '{o_payload_byte, o_payload_valid, o_frame_end, o_length_error,
                    o_crc_error, o_remote_error, o_short_frame, o_sequence_number};
            results_checked++;
            if (predicted_outputs.size() == 0) begin
                flag_error({"unexpected result: ", fmt_result(got)});
            end else begin
                want = predicted_outputs.pop_front();
                if (got !== want) begin
                    flag_error({"result mismatch\n  expected ", fmt_result(want),
                                "\n  actual   ", fmt_result(got)});
                end
            end
        end
    end

    // Test sequence: reset, directed frames, then four random phases with
    // different idle and stall mixes
    initial begin : run_test
        byte_q_t body;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            if (phase == 0) begin
                // Single-byte frame of all ones: the shortest possible frame
                body = '{8'hff};
                push_frame(body);
                // Minimum well-formed frame with empty payload, all-ones sequence
                body.delete();
                queue_frame(body, 32'hffff_ffff, FLAW_NONE);
                // Remote error frame: payload passes through while the flag is raised
                body = '{8'h6c, 8'hfe, 8'hff, 8'hff};
                queue_frame(body, 32'h0000_0000, FLAW_NONE);
            end
            queue_random_frames(PhaseBytes);
            // Drain: every byte transferred and every prediction matched
            while (!(bytes_accepted == bytes_queued && predicted_outputs.size() == 0))
                @(posedge i_clk);
        end

        // Let any stray result surface before closing
        repeat (10) @(posedge i_clk);
        if (predicted_outputs.size() != 0)
            flag_error($sformatf("%0d predicted results never arrived",
                                 predicted_outputs.size()));

        $display("Ran %0d frames (%0d bytes), %0d results compared, %0d mismatches.",
                 frames_closed, bytes_accepted, results_checked, fail_count);
        $display("Frames flagged: length %0d, crc %0d, remote %0d, short %0d.",
                 len_err_frames, crc_err_frames, remote_frames, short_frames);
        if (fail_count == 0) begin
            $display("transport_frame_checker_top verification clean");
        end else begin
            $display("transport_frame_checker_top verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tfc_pkg.sv
hw/rtl/tfc_tracker.sv
hw/rtl/transport_frame_checker_top.sv
dv/tb_top.sv
